[rtl/fba_pkg.sv]
package fba_pkg;

    localparam int FRAME_COUNT  = 32768;
    localparam int WORD_BITS    = 32;

    // Frame numbers travel in 15-bit fields; frames past that are never named.
    localparam int FRAME_W      = 15;
    localparam int FIELD_FRAMES = 1 << FRAME_W;
    localparam int NUM_FRAMES   = (FRAME_COUNT < FIELD_FRAMES) ? FRAME_COUNT : FIELD_FRAMES;

    // Bit and word indexes are taken apart by shifts: WORD_BITS is a power of two.
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int WORD_COUNT   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int GROUP_COUNT  = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int GADDR_W      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    localparam int LAST_WORD_BITS   = NUM_FRAMES - (WORD_COUNT - 1) * WORD_BITS;
    localparam int LAST_GROUP_WORDS = WORD_COUNT - (GROUP_COUNT - 1) * WORD_BITS;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_CLAIM = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [FRAME_W-1:0]   t_frame;

    // Bits at and above n set: marks slots past the end as permanently used.
    function automatic t_word high_mask(int n);
        t_word m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i >= n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam t_word WORD_PAD = high_mask(LAST_WORD_BITS);
    localparam t_word SUM_PAD  = high_mask(LAST_GROUP_WORDS);

    typedef struct packed {
        logic [1:0] func;
        logic       entry_present;
        logic       entry_writable;
        logic       entry_user;
        t_frame     entry_frame;
        t_frame     target_frame;
        logic       kernel_page;
        logic       want_writable;
    } t_fba_in;

    typedef struct packed {
        logic   out_present;
        logic   out_writable;
        logic   out_user;
        t_frame out_frame;
        logic   out_of_frames;
    } t_fba_out;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic sum_step;
        logic word_step;
        logic push;
    } t_fba_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_fba_sts;

endpackage

[rtl/frame_bitmap_allocator_core.sv]
// First-fit page frame allocator. One used-bit per physical frame lives in a
// bitmap RAM of WORD_COUNT words (1024 x 32 bits by default); a summary RAM
// keeps one "word full" bit per bitmap word and a flop vector keeps one
// "group full" bit per summary word, so the lowest free frame is found in two
// RAM reads. After reset the block sweeps both RAMs, one word a cycle, and
// holds stall high until the sweep is done. Each transaction then runs
// through the summary read at the accepting edge, the dependent bitmap
// read, the write-back of both RAMs, and the load of the output register.
// A new transaction is taken only once the last one has loaded the output
// register. A new transaction is taken while a finished result still waits
// in the output register. An allocate on a full bitmap returns the entry
// unchanged with out_of_frames set; claims and frees past the last frame
// build their entries but leave the bitmap alone.
module frame_bitmap_allocator_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fba_pkg::t_fba_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fba_pkg::t_fba_out o_out_data
);
    import fba_pkg::*;

    // Commands from the sequencer, status back from the datapath
    t_fba_cmd cmd;
    t_fba_sts sts;

    // Sequence clearing, accept, the two reads, write-back and output load
    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the request, the bitmap and summary RAMs, and the output register
    fba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/fba_ram.sv]
module fba_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fba_ctrl.sv]
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fba_pkg::t_fba_sts i_sts,
    output fba_pkg::t_fba_cmd o_cmd
);
    import fba_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SUM   = 5'b00100,
        S_WORD  = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_state        = S_WORD;
            end
            S_WORD: begin
                o_cmd.word_step = 1'b1;
                n_state         = S_PUSH;
            end
            S_PUSH: begin
                // Hold the result until the output register frees up.
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/fba_dp.sv]
module fba_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fba_pkg::t_fba_cmd i_cmd,
    output fba_pkg::t_fba_sts o_sts,
    input  fba_pkg::t_fba_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fba_pkg::t_fba_out o_out_data
);
    import fba_pkg::*;

    typedef enum logic [1:0] {
        ACT_PASS,
        ACT_ALLOC,
        ACT_CLAIM,
        ACT_FREE
    } t_act;

    function automatic logic [BIT_W-1:0] first_zero_bit(t_word v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [GADDR_W-1:0] first_zero_group(logic [GROUP_COUNT-1:0] v);
        logic [GADDR_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = GADDR_W'(i);
            end
        end
        return idx;
    endfunction

    // Request and decoded action
    t_fba_in              r_req;
    t_act                 r_act, n_act;
    logic                 r_touch, n_touch;
    logic                 r_oof, n_oof;
    t_frame               r_frame;
    logic [GADDR_W-1:0]   r_g, n_g;
    logic [WADDR_W-1:0]   r_w, n_w;

    logic [GROUP_COUNT-1:0] r_top;
    logic [WADDR_W-1:0]     r_clr;

    t_fba_out r_res, n_res;
    t_fba_out r_out;
    logic     r_out_valid;

    t_word sum_rdata, word_rdata;

    // Accept-time decode
    t_frame             in_frame;
    logic               in_range;
    logic [WADDR_W-1:0] in_word;

    always_comb begin
        in_frame = (i_in_data.func == FUNC_CLAIM) ? i_in_data.target_frame
                                                  : i_in_data.entry_frame;
        in_range = ({1'b0, in_frame} < (FRAME_W + 1)'(NUM_FRAMES));
        in_word  = WADDR_W'(in_frame >> BIT_W);

        n_act   = ACT_PASS;
        n_touch = 1'b0;
        n_oof   = 1'b0;
        n_g     = GADDR_W'(in_word >> BIT_W);
        case (i_in_data.func)
            FUNC_ALLOC: begin
                if (!i_in_data.entry_present) begin
                    if (&r_top) begin
                        n_oof = 1'b1;
                    end else begin
                        n_act   = ACT_ALLOC;
                        n_touch = 1'b1;
                        n_g     = first_zero_group(r_top);
                    end
                end
            end
            FUNC_CLAIM: begin
                n_act   = ACT_CLAIM;
                n_touch = in_range;
            end
            FUNC_FREE: begin
                if (in_frame != '0) begin
                    n_act   = ACT_FREE;
                    n_touch = in_range;
                end
            end
            default: begin
                n_act = ACT_PASS;
            end
        endcase
    end

    // Word pick after the summary read
    always_comb begin
        if (r_act == ACT_ALLOC) begin
            n_w = WADDR_W'({r_g, first_zero_bit(sum_rdata)});
        end else begin
            n_w = WADDR_W'(r_frame >> BIT_W);
        end
    end

    // Update and result after the bitmap read
    logic [BIT_W-1:0] bit_idx;
    logic [BIT_W-1:0] word_slot;
    t_word            bit_mask, slot_mask;
    t_word            new_word, new_sum;
    logic             set_bit;

    always_comb begin
        bit_idx   = (r_act == ACT_ALLOC) ? first_zero_bit(word_rdata) : BIT_W'(r_frame);
        word_slot = BIT_W'(r_w);
        bit_mask  = t_word'(1) << bit_idx;
        slot_mask = t_word'(1) << word_slot;
        set_bit   = (r_act != ACT_FREE);
        new_word  = set_bit ? (word_rdata | bit_mask) : (word_rdata & ~bit_mask);
        new_sum   = (&new_word) ? (sum_rdata | slot_mask) : (sum_rdata & ~slot_mask);

        n_res.out_present   = r_req.entry_present;
        n_res.out_writable  = r_req.entry_writable;
        n_res.out_user      = r_req.entry_user;
        n_res.out_frame     = r_req.entry_frame;
        n_res.out_of_frames = r_oof;
        case (r_act)
            ACT_ALLOC, ACT_CLAIM: begin
                n_res.out_present  = 1'b1;
                n_res.out_writable = r_req.want_writable;
                n_res.out_user     = !r_req.kernel_page;
                n_res.out_frame    = (r_act == ACT_ALLOC) ? t_frame'({r_w, bit_idx})
                                                          : r_frame;
            end
            ACT_FREE: begin
                n_res.out_present = 1'b0;
                n_res.out_frame   = '0;
            end
            default: begin
                n_res.out_of_frames = r_oof;
            end
        endcase
    end

    // Memories
    logic               word_we, sum_we;
    logic [WADDR_W-1:0] word_waddr;
    logic [GADDR_W-1:0] sum_waddr;
    t_word              word_wdata, sum_wdata;

    always_comb begin
        if (i_cmd.clear_wr) begin
            word_we    = 1'b1;
            word_waddr = r_clr;
            word_wdata = (r_clr == WADDR_W'(WORD_COUNT - 1)) ? WORD_PAD : '0;
            sum_we     = ({1'b0, r_clr} < (WADDR_W + 1)'(GROUP_COUNT));
            sum_waddr  = GADDR_W'(r_clr);
            sum_wdata  = (GADDR_W'(r_clr) == GADDR_W'(GROUP_COUNT - 1)) ? SUM_PAD : '0;
        end else begin
            word_we    = i_cmd.word_step && r_touch;
            word_waddr = r_w;
            word_wdata = new_word;
            sum_we     = i_cmd.word_step && r_touch;
            sum_waddr  = r_g;
            sum_wdata  = new_sum;
        end
    end

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (word_waddr),
        .i_wdata (word_wdata),
        .i_re    (i_cmd.sum_step),
        .i_raddr (n_w),
        .o_rdata (word_rdata)
    );

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (GROUP_COUNT)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (n_g),
        .o_rdata (sum_rdata)
    );

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.word_step && r_touch) begin
                r_top[r_g] <= &new_sum;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_in_data;
            r_act   <= n_act;
            r_touch <= n_touch;
            r_oof   <= n_oof;
            r_frame <= in_frame;
            r_g     <= n_g;
        end
        if (i_cmd.sum_step) begin
            r_w <= n_w;
        end
        if (i_cmd.word_step) begin
            r_res <= n_res;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_sts.clear_last = (r_clr == WADDR_W'(WORD_COUNT - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule
